// ----- rtl/dmarb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarb_pkg
// Shared types, codes, register offsets and field packing for the DMA
// controller register bank.
// ----------------------------------------------------------------------------
package dmarb_pkg;

  typedef enum logic [2:0] {
    CMD_REG_RD  = 3'd0,
    CMD_REG_WR  = 3'd1,
    CMD_EN_WR   = 3'd2,
    CMD_EN_RD   = 3'd3,
    CMD_SET_REQ = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHAN  = 2'd1;
  localparam logic [1:0] ST_UNHANDLED = 2'd2;
  localparam logic [1:0] ST_SUSPEND   = 2'd3;

  typedef enum logic [3:0] {
    RK_CTRL,
    RK_MADR,
    RK_QWC,
    RK_TADR,
    RK_ASR0,
    RK_ASR1,
    RK_SADR,
    RK_GCTRL,
    RK_STAT,
    RK_PCR,
    RK_SINK,
    RK_NONE
  } reg_kind_t;

  typedef struct packed {
    logic      is_global;
    logic      chan_hit;
    logic [3:0] chan;
    reg_kind_t kind;
  } dec_t;

  localparam int          NUM_SEL = 10;
  localparam int          MAX_CH  = 16;
  localparam logic [7:0]  CHAN_SEL [NUM_SEL] = '{
    8'h80, 8'h90, 8'hA0, 8'hB0, 8'hB4, 8'hC0, 8'hC4, 8'hC8, 8'hD0, 8'hD4
  };

  localparam logic [15:0] GLOBAL_BASE = 16'hE000;
  localparam logic [15:0] OFF_GCTRL   = 16'hE000;
  localparam logic [15:0] OFF_STAT    = 16'hE010;
  localparam logic [15:0] OFF_PCR     = 16'hE020;
  localparam logic [15:0] OFF_SINK0   = 16'hE030;
  localparam logic [15:0] OFF_SINK1   = 16'hE040;
  localparam logic [15:0] OFF_SINK2   = 16'hE050;

  localparam logic [7:0] CH_CTRL = 8'h00;
  localparam logic [7:0] CH_MADR = 8'h10;
  localparam logic [7:0] CH_QWC  = 8'h20;
  localparam logic [7:0] CH_TADR = 8'h30;
  localparam logic [7:0] CH_ASR0 = 8'h40;
  localparam logic [7:0] CH_ASR1 = 8'h50;
  localparam logic [7:0] CH_SADR = 8'h80;

  localparam logic [31:0] EN_RST         = 32'h0000_1201;
  localparam int          EN_SUSPEND_BIT = 16;
  localparam int          CTRL_START_BIT = 7;
  localparam int          GCTRL_DMAE_BIT = 0;
  localparam int          PCR_PCE_BIT    = 20;

  // Channel control: stored compact, bus word has bit 1 and bits 31:9 as zero.
  function automatic logic [31:0] pack_ctrl(input logic [7:0] c);
    pack_ctrl = {23'd0, c[7], c[6], c[5], c[4:3], c[2:1], 1'b0, c[0]};
  endfunction

  function automatic logic [7:0] unpack_ctrl(input logic [31:0] d);
    unpack_ctrl = {d[8], d[7], d[6], d[5:4], d[3:2], d[0]};
  endfunction

  function automatic logic [31:0] pack_stat(input logic [24:0] s);
    pack_stat = {1'b0, s[24], s[23], 3'd0, s[22:13], s[12], s[11], s[10], 3'd0,
                 s[9:0]};
  endfunction

  // Set bits clear pending interrupts; mask bits toggle.
  function automatic logic [24:0] write_stat(input logic [24:0] s, input logic [31:0] d);
    write_stat = {s[24] ^ d[30], s[23] ^ d[29], s[22:13] ^ d[25:16],
                  s[12] & ~d[15], s[11] & ~d[14], s[10] & ~d[13], s[9:0] & ~d[9:0]};
  endfunction

  function automatic logic [31:0] pack_pcr(input logic [20:0] p);
    pack_pcr = {p[20], 5'd0, p[19:10], 6'd0, p[9:0]};
  endfunction

  function automatic logic [20:0] unpack_pcr(input logic [31:0] d);
    unpack_pcr = {d[31], d[25:16], d[9:0]};
  endfunction

endpackage

// ----- rtl/dmarb_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarb_decode
// Address decode: channel select from bits 15:8 and register kind.
// ----------------------------------------------------------------------------
module dmarb_decode (
  input  logic [15:0]     reg_offset,
  output dmarb_pkg::dec_t dec
);
  import dmarb_pkg::*;

  always_comb begin
    dec.is_global = (reg_offset >= GLOBAL_BASE);
    dec.chan_hit  = 1'b0;
    dec.chan      = 4'd0;
    for (int i = 0; i < NUM_SEL; i++) begin
      if (reg_offset[15:8] == CHAN_SEL[i]) begin
        dec.chan_hit = 1'b1;
        dec.chan     = 4'(i);
      end
    end
    dec.kind = RK_NONE;
    if (dec.is_global) begin
      case (reg_offset)
        OFF_GCTRL: dec.kind = RK_GCTRL;
        OFF_STAT:  dec.kind = RK_STAT;
        OFF_PCR:   dec.kind = RK_PCR;
        OFF_SINK0: dec.kind = RK_SINK;
        OFF_SINK1: dec.kind = RK_SINK;
        OFF_SINK2: dec.kind = RK_SINK;
        default:   dec.kind = RK_NONE;
      endcase
    end else begin
      case (reg_offset[7:0])
        CH_CTRL: dec.kind = RK_CTRL;
        CH_MADR: dec.kind = RK_MADR;
        CH_QWC:  dec.kind = RK_QWC;
        CH_TADR: dec.kind = RK_TADR;
        CH_ASR0: dec.kind = RK_ASR0;
        CH_ASR1: dec.kind = RK_ASR1;
        CH_SADR: dec.kind = RK_SADR;
        default: dec.kind = RK_NONE;
      endcase
    end
  end

endmodule

// ----- rtl/dmarb_arb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarb_arb
// Fixed-priority pick of the lowest channel ready to start.
// ----------------------------------------------------------------------------
module dmarb_arb #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic [NUM_CHANNELS-1:0] elig,
  output logic                    flag,
  output logic [3:0]              chan
);
  import dmarb_pkg::*;

  always_comb begin
    flag = 1'b0;
    chan = 4'd0;
    // Scan downward so the lowest ready channel wins.
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (elig[i]) begin
        flag = 1'b1;
        chan = 4'(i);
      end
    end
  end

endmodule

// ----- rtl/dma_controller_register_bank_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_controller_register_bank_core
// Register bank of a multi-channel DMA controller with start arbitration.
// ----------------------------------------------------------------------------
// Pipeline: input register, then state update and result register together.
// Throughput: one item per cycle; busy stays low, decode and update are one
//   register-to-register pass.
// Reset: synchronous, active low; state registers zero, enable word 0x1201,
//   request lines set except channels 3 and 5. Results cannot be stalled.
module dma_controller_register_bank_core #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_reg_offset,
  input  logic [31:0] in_wdata,
  input  logic [3:0]  in_req_channel,
  input  logic        in_req_level,
  output logic        out_valid,
  output logic [31:0] out_rdata,
  output logic [1:0]  out_status_code,
  output logic        out_start_flag,
  output logic [3:0]  out_start_channel
);
  import dmarb_pkg::*;

  localparam int         CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [4:0] NUM_CH5 = 5'(NUM_CHANNELS);

  // input register
  logic        in_vld_r;
  logic [2:0]  cmd_r;
  logic [15:0] off_r;
  logic [31:0] wdata_r;
  logic [3:0]  rch_r;
  logic        lvl_r;

  // state
  logic [7:0]  chan_control_r     [NUM_CHANNELS];
  logic [7:0]  chan_control_nxt   [NUM_CHANNELS];
  logic [27:0] chan_mem_addr_r    [NUM_CHANNELS];
  logic [15:0] chan_qw_count_r    [NUM_CHANNELS];
  logic [27:0] chan_tag_addr_r    [NUM_CHANNELS];
  logic [27:0] chan_stack_addr0_r [NUM_CHANNELS];
  logic [27:0] chan_stack_addr1_r [NUM_CHANNELS];
  logic [27:0] chan_stall_addr_r  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_request_r, chan_request_nxt;
  logic [10:0] global_control_r, global_control_nxt;
  logic [24:0] irq_status_mask_r, irq_status_mask_nxt;
  logic [20:0] priority_control_r, priority_control_nxt;
  logic [31:0] enable_word_r, enable_word_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] out_rdata_r, out_rdata_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_start_flag_r;
  logic [3:0]  out_start_channel_r;

  dec_t                    dec;
  logic                    chan_ok;
  logic [CH_W-1:0]         idx;
  logic                    addr_we;
  logic [NUM_CHANNELS-1:0] elig;
  logic [MAX_CH-1:0]       cde_ext;
  logic                    arb_flag;
  logic [3:0]              arb_chan;

  assign busy = 1'b0;

  dmarb_decode u_decode (
    .reg_offset (off_r),
    .dec        (dec)
  );

  assign chan_ok = dec.chan_hit && ({1'b0, dec.chan} < NUM_CH5);
  assign idx     = dec.chan[CH_W-1:0];
  assign addr_we = in_vld_r && (cmd_r == CMD_REG_WR) && !dec.is_global && chan_ok;

  always_comb begin
    chan_control_nxt     = chan_control_r;
    chan_request_nxt     = chan_request_r;
    global_control_nxt   = global_control_r;
    irq_status_mask_nxt  = irq_status_mask_r;
    priority_control_nxt = priority_control_r;
    enable_word_nxt      = enable_word_r;
    out_rdata_nxt        = 32'd0;
    out_status_nxt       = ST_OK;
    if (in_vld_r) begin
      case (cmd_r)
        CMD_REG_RD: begin
          if (!dec.is_global) begin
            if (!chan_ok)                 out_status_nxt = ST_BAD_CHAN;
            else if (dec.kind != RK_CTRL) out_status_nxt = ST_UNHANDLED;
            else                          out_rdata_nxt  = pack_ctrl(chan_control_r[idx]);
          end else begin
            case (dec.kind)
              RK_GCTRL: out_rdata_nxt  = {21'd0, global_control_r};
              RK_STAT:  out_rdata_nxt  = pack_stat(irq_status_mask_r);
              RK_PCR:   out_rdata_nxt  = pack_pcr(priority_control_r);
              default:  out_status_nxt = ST_UNHANDLED;
            endcase
          end
        end
        CMD_REG_WR: begin
          if (!dec.is_global) begin
            if (!chan_ok)                 out_status_nxt = ST_BAD_CHAN;
            else if (dec.kind == RK_NONE) out_status_nxt = ST_UNHANDLED;
            else if (dec.kind == RK_CTRL) chan_control_nxt[idx] = unpack_ctrl(wdata_r);
          end else begin
            case (dec.kind)
              RK_GCTRL: global_control_nxt   = wdata_r[10:0];
              RK_STAT:  irq_status_mask_nxt  = write_stat(irq_status_mask_r, wdata_r);
              RK_PCR:   priority_control_nxt = unpack_pcr(wdata_r);
              RK_SINK:  out_status_nxt       = ST_OK;
              default:  out_status_nxt       = ST_UNHANDLED;
            endcase
          end
        end
        CMD_EN_WR: begin
          if (wdata_r[EN_SUSPEND_BIT]) out_status_nxt  = ST_SUSPEND;
          else                         enable_word_nxt = wdata_r;
        end
        CMD_EN_RD: out_rdata_nxt = enable_word_r;
        CMD_SET_REQ: begin
          if ({1'b0, rch_r} < NUM_CH5) chan_request_nxt[rch_r[CH_W-1:0]] = lvl_r;
          else                         out_status_nxt = ST_BAD_CHAN;
        end
        default: out_status_nxt = ST_OK;
      endcase
    end
  end

  // Start check sees the state as this item leaves it.
  assign cde_ext = {{(MAX_CH - NUM_SEL){1'b0}}, priority_control_nxt[19:10]};

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      elig[i] = chan_request_nxt[i] && chan_control_nxt[i][CTRL_START_BIT] &&
                (!priority_control_nxt[PCR_PCE_BIT] || cde_ext[i]) &&
                !enable_word_nxt[EN_SUSPEND_BIT] && global_control_nxt[GCTRL_DMAE_BIT];
    end
  end

  dmarb_arb #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_arb (
    .elig (elig),
    .flag (arb_flag),
    .chan (arb_chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r            <= 1'b0;
      out_valid_r         <= 1'b0;
      out_start_flag_r    <= 1'b0;
      out_start_channel_r <= 4'd0;
      global_control_r    <= '0;
      irq_status_mask_r   <= '0;
      priority_control_r  <= '0;
      enable_word_r       <= EN_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_control_r[i]     <= '0;
        chan_mem_addr_r[i]    <= '0;
        chan_qw_count_r[i]    <= '0;
        chan_tag_addr_r[i]    <= '0;
        chan_stack_addr0_r[i] <= '0;
        chan_stack_addr1_r[i] <= '0;
        chan_stall_addr_r[i]  <= '0;
        chan_request_r[i]     <= !(i == 3 || i == 5);
      end
    end else begin
      in_vld_r            <= start;
      out_valid_r         <= in_vld_r;
      out_start_flag_r    <= arb_flag;
      out_start_channel_r <= arb_chan;
      chan_control_r      <= chan_control_nxt;
      chan_request_r      <= chan_request_nxt;
      global_control_r    <= global_control_nxt;
      irq_status_mask_r   <= irq_status_mask_nxt;
      priority_control_r  <= priority_control_nxt;
      enable_word_r       <= enable_word_nxt;
      if (addr_we) begin
        case (dec.kind)
          RK_MADR: chan_mem_addr_r[idx]    <= wdata_r[31:4];
          RK_QWC:  chan_qw_count_r[idx]    <= wdata_r[15:0];
          RK_TADR: chan_tag_addr_r[idx]    <= wdata_r[31:4];
          RK_ASR0: chan_stack_addr0_r[idx] <= wdata_r[31:4];
          RK_ASR1: chan_stack_addr1_r[idx] <= wdata_r[31:4];
          RK_SADR: chan_stall_addr_r[idx]  <= wdata_r[31:4];
          default: chan_stall_addr_r[idx]  <= chan_stall_addr_r[idx];
        endcase
      end
    end
  end

  // payload: hold the item fields and the result data
  always_ff @(posedge clk) begin
    cmd_r        <= in_cmd;
    off_r        <= in_reg_offset;
    wdata_r      <= in_wdata;
    rch_r        <= in_req_channel;
    lvl_r        <= in_req_level;
    out_rdata_r  <= out_rdata_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rdata         = out_rdata_r;
  assign out_status_code   = out_status_r;
  assign out_start_flag    = out_start_flag_r;
  assign out_start_channel = out_start_channel_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid_r)
    else $error("accepted item produced no result");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_rdata_r == 32'd0))
    else $error("error result carries read data");

  a_idle_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_start_flag_r |-> (out_start_channel_r == 4'd0))
    else $error("start channel nonzero without start flag");

  a_start_needs_dmae: assert property (@(posedge clk) disable iff (!rst_n)
    out_start_flag_r |-> global_control_r[GCTRL_DMAE_BIT])
    else $error("start flagged with DMA disabled");

  a_no_suspend: assert property (@(posedge clk) disable iff (!rst_n)
    !enable_word_r[EN_SUSPEND_BIT])
    else $error("suspend bit latched in enable word");

endmodule
